// ===== rtl/sdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpq_pkg
// Shared types, reset values and helpers of the step/dir pulse queue engine.
// ----------------------------------------------------------------------------
package sdpq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 32;

    localparam logic [15:0] PULSE_WIDTH_RST = 16'd160;
    localparam logic        DIR_ENABLE_RST  = 1'b1;
    localparam logic [15:0] CUR_TOP_RST     = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_PULSE_WIDTH = 1'b0,
        CFG_DIR_ENABLE  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] period_ticks;
        logic [7:0]  repeat_count;
        logic        with_step;
        logic        flip_dir;
    } sdpq_item_t;

    typedef struct packed {
        logic step_level;
        logic dir_level;
        logic running;
        logic accepted;
        logic period_end;
    } sdpq_result_t;

    typedef struct packed {
        logic        flip_dir;
        logic        with_step;
        logic [7:0]  repeat_count;
        logic [15:0] period_ticks;
    } cmd_entry_t;

    typedef struct packed {
        logic [15:0] top;
        logic        pulse;
        logic        flip;
        logic        pop;
        logic [7:0]  used;
        logic        flipped;
    } take_t;

    typedef struct packed {
        logic       push;
        cmd_entry_t entry;
        logic [1:0] pop_cnt;
        logic       flush;
    } q_ctrl_t;

    typedef struct packed {
        cmd_entry_t head0;
        cmd_entry_t head1;
        logic       nonempty;
        logic       two;
        logic       full;
    } q_status_t;

    // one period from an entry that has already been played used times
    function automatic take_t take_period(cmd_entry_t e, logic [7:0] used, logic flipped);
        take_t      t;
        logic [7:0] rem;
        rem       = e.repeat_count - used;
        t.top     = e.period_ticks;
        t.pulse   = e.with_step;
        t.flip    = e.flip_dir & ~flipped;
        t.pop     = (rem <= 8'd1);
        t.used    = t.pop ? 8'd0 : used + 8'd1;
        t.flipped = ~t.pop;
        return t;
    endfunction

endpackage

// ===== rtl/sdpq_if.sv =====
// ----------------------------------------------------------------------------
// sdpq_cmd_if / sdpq_res_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface sdpq_cmd_if;
    import sdpq_pkg::*;

    logic       valid;
    logic       ready;
    sdpq_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdpq_res_if;
    import sdpq_pkg::*;

    logic         valid;
    logic         ready;
    sdpq_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/step_dir_pulse_queue_engine.sv =====
// ----------------------------------------------------------------------------
// step_dir_pulse_queue_engine
// Step/dir pulse generator driven by a queue of period commands.
//
// Items arrive on cmd (tick, push, start, force stop); every item gives one
// result on res with the STEP and DIR levels, the running flag, whether a
// push or start was taken and whether a tick closed a period.
// Each transfer on cmd lands in an input register, is applied to the state
// once the output register is free or being taken, and its result is held
// in the output register until res takes it.
// One item per cycle is sustained while res is ready; the state update of an
// item is combinational, and the queue RAM is kept one read ahead of its head.
// When res stalls, the output register holds the result, one more item waits
// in the input register and cmd.ready drops; nothing is lost.
// Reset clears the queue and stops the generator (STEP and DIR low, pulse
// width 160 ticks, direction flips enabled). The RAM needs no clearing pass.
// pulse_width and dir_enable are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while no item is in flight, as the block has no check.
// ----------------------------------------------------------------------------
module step_dir_pulse_queue_engine #(
    parameter int unsigned QUEUE_DEPTH = sdpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  sdpq_pkg::cfg_index_t   cfg_index,
    input  logic [15:0]            cfg_data,
    sdpq_cmd_if.sink               cmd,
    sdpq_res_if.source             res
);
    import sdpq_pkg::*;

    logic         in_valid_reg;
    sdpq_item_t   in_item_reg;
    logic         out_valid_reg;
    sdpq_result_t out_data_reg;
    logic [15:0]  pulse_width_reg;
    logic         dir_enable_reg;
    logic         advance;
    logic         fire;
    q_ctrl_t      q_ctrl;
    q_status_t    q_sts;
    sdpq_result_t result;

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= PULSE_WIDTH_RST;
            dir_enable_reg  <= DIR_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_WIDTH: pulse_width_reg <= cfg_data;
                CFG_DIR_ENABLE:  dir_enable_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg <= cmd.data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    sdpq_pulse_gen u_pulse_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_item_reg),
        .pulse_width (pulse_width_reg),
        .dir_enable  (dir_enable_reg),
        .q_sts       (q_sts),
        .q_ctrl      (q_ctrl),
        .result      (result)
    );

    sdpq_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .sts   (q_sts)
    );

`ifndef SYNTH
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.pop_cnt != 2'd0 |-> q_sts.nonempty)
        else $error("queue popped while empty");

    a_double_pop_two: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.pop_cnt == 2'd2 |-> q_sts.two)
        else $error("two heads popped with fewer than two queued");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.push |-> !q_sts.full)
        else $error("push written into a full queue");

    a_step_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!res.data.step_level || res.data.running))
        else $error("step high while stopped");

    a_end_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> !(out_data_reg.period_end && out_data_reg.accepted))
        else $error("period end flagged on an accepted command");
`endif

endmodule

// ===== rtl/sdpq_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sdpq_cmd_queue
// Command queue: a RAM with registered read behind three prefetched head
// registers, so up to two heads can be popped in one cycle.
// ----------------------------------------------------------------------------
module sdpq_cmd_queue #(
    parameter int unsigned QUEUE_DEPTH = sdpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sdpq_pkg::q_ctrl_t   ctrl,
    output sdpq_pkg::q_status_t sts
);
    import sdpq_pkg::*;

    localparam int unsigned AW          = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned FRONT_DEPTH = 3;

    cmd_entry_t          mem [QUEUE_DEPTH];
    cmd_entry_t          front_reg [FRONT_DEPTH];
    cmd_entry_t          front_next [FRONT_DEPTH];
    cmd_entry_t          shifted [FRONT_DEPTH];
    cmd_entry_t          land_reg;
    logic                land_v_reg, land_v_next;
    logic [1:0]          fcnt_reg, fcnt_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       mem_cnt_reg, mem_cnt_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [1:0]          f_pop;
    logic [1:0]          f_land;
    logic                push_front;
    logic                push_mem;
    logic                rd_en;

    always_comb
    begin
        f_pop      = fcnt_reg - ctrl.pop_cnt;
        f_land     = f_pop + 2'(land_v_reg);
        push_front = ctrl.push && (mem_cnt_reg == '0) && (f_land != 2'(FRONT_DEPTH));
        push_mem   = ctrl.push && !push_front;
        rd_en      = (mem_cnt_reg != '0) && (f_land != 2'(FRONT_DEPTH)) && !ctrl.flush;

        for (int i = 0; i < FRONT_DEPTH; i++)
        begin
            shifted[i] = front_reg[i];
            if (ctrl.pop_cnt == 2'd1 && i + 1 < FRONT_DEPTH)
            begin
                shifted[i] = front_reg[i + 1];
            end
            if (ctrl.pop_cnt == 2'd2 && i + 2 < FRONT_DEPTH)
            begin
                shifted[i] = front_reg[i + 2];
            end
        end

        for (int i = 0; i < FRONT_DEPTH; i++)
        begin
            if (2'(i) < f_pop)
            begin
                front_next[i] = shifted[i];
            end
            else if (land_v_reg && 2'(i) == f_pop)
            begin
                front_next[i] = land_reg;
            end
            else if (push_front && 2'(i) == f_land)
            begin
                front_next[i] = ctrl.entry;
            end
            else
            begin
                front_next[i] = shifted[i];
            end
        end

        fcnt_next    = f_land + 2'(push_front);
        land_v_next  = rd_en;
        mem_cnt_next = mem_cnt_reg - CW'(rd_en) + CW'(push_mem);
        total_next   = total_reg - CW'(ctrl.pop_cnt) + CW'(ctrl.push);
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        if (push_mem)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        // force stop drops every queued command
        if (ctrl.flush)
        begin
            fcnt_next    = '0;
            land_v_next  = 1'b0;
            mem_cnt_next = '0;
            total_next   = '0;
            wr_ptr_next  = '0;
            rd_ptr_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg    <= '0;
            land_v_reg  <= 1'b0;
            mem_cnt_reg <= '0;
            total_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end
        else
        begin
            fcnt_reg    <= fcnt_next;
            land_v_reg  <= land_v_next;
            mem_cnt_reg <= mem_cnt_next;
            total_reg   <= total_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRONT_DEPTH; i++)
        begin
            front_reg[i] <= front_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_mem)
        begin
            mem[wr_ptr_reg] <= ctrl.entry;
        end
        if (rd_en)
        begin
            land_reg <= mem[rd_ptr_reg];
        end
    end

    assign sts.head0    = front_reg[0];
    assign sts.head1    = front_reg[1];
    assign sts.nonempty = (total_reg != '0);
    assign sts.two      = (total_reg > CW'(1));
    assign sts.full     = (total_reg == CW'(QUEUE_DEPTH));

endmodule

// ===== rtl/sdpq_pulse_gen.sv =====
// ----------------------------------------------------------------------------
// sdpq_pulse_gen
// Period counter, staged period, grace handling and direction state; one
// input item is applied per cycle when fire is high, and its result is formed alongside.
// ----------------------------------------------------------------------------
module sdpq_pulse_gen (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  sdpq_pkg::sdpq_item_t   item,
    input  logic [15:0]            pulse_width,
    input  logic                   dir_enable,
    input  sdpq_pkg::q_status_t    q_sts,
    output sdpq_pkg::q_ctrl_t      q_ctrl,
    output sdpq_pkg::sdpq_result_t result
);
    import sdpq_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] cur_top_reg, cur_top_next;
    logic        cur_pulse_reg, cur_pulse_next;
    logic [15:0] stg_top_reg, stg_top_next;
    logic        stg_pulse_reg, stg_pulse_next;
    logic        grace_reg, grace_next;
    logic        active_reg, active_next;
    logic        dir_reg, dir_next;
    logic [7:0]  used_reg, used_next;
    logic        flipped_reg, flipped_next;

    take_t       t0;
    take_t       t1;
    logic        t1_ok;
    logic        use0;
    logic        use1;
    logic        push;
    logic        flush;
    logic        accepted;
    logic        period_end;

    always_comb
    begin
        t0 = take_period(q_sts.head0, used_reg, flipped_reg);
        if (t0.pop)
        begin
            t1 = take_period(q_sts.head1, 8'd0, 1'b0);
        end
        else
        begin
            t1 = take_period(q_sts.head0, t0.used, t0.flipped);
        end
        t1_ok = !t0.pop || q_sts.two;

        pos_next       = pos_reg;
        cur_top_next   = cur_top_reg;
        cur_pulse_next = cur_pulse_reg;
        stg_top_next   = stg_top_reg;
        stg_pulse_next = stg_pulse_reg;
        grace_next     = grace_reg;
        active_next    = active_reg;
        use0           = 1'b0;
        use1           = 1'b0;
        push           = 1'b0;
        flush          = 1'b0;
        accepted       = 1'b0;
        period_end     = 1'b0;
        used_next      = used_reg;
        flipped_next   = flipped_reg;

        case (item.kind)
            KIND_TICK:
            begin
                if (active_reg)
                begin
                    if (pos_reg >= cur_top_reg)
                    begin
                        period_end     = 1'b1;
                        pos_next       = '0;
                        cur_top_next   = stg_top_reg;
                        cur_pulse_next = stg_pulse_reg;
                        if (q_sts.nonempty)
                        begin
                            use0           = 1'b1;
                            stg_top_next   = t0.top;
                            stg_pulse_next = t0.pulse;
                            grace_next     = 1'b0;
                        end
                        else if (grace_reg)
                        begin
                            grace_next  = 1'b0;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            // dead period keeps the length of the one just latched
                            grace_next     = 1'b1;
                            stg_pulse_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 16'd1;
                    end
                end
            end
            KIND_PUSH:
            begin
                if (!q_sts.full)
                begin
                    push     = 1'b1;
                    accepted = 1'b1;
                end
            end
            KIND_START:
            begin
                if (!active_reg && q_sts.nonempty)
                begin
                    use0           = 1'b1;
                    active_next    = 1'b1;
                    grace_next     = 1'b0;
                    cur_top_next   = t0.top;
                    cur_pulse_next = t0.pulse;
                    pos_next       = '0;
                    accepted       = 1'b1;
                    if (t1_ok)
                    begin
                        use1           = 1'b1;
                        stg_top_next   = t1.top;
                        stg_pulse_next = t1.pulse;
                    end
                    else
                    begin
                        grace_next     = 1'b1;
                        stg_top_next   = t0.top;
                        stg_pulse_next = 1'b0;
                    end
                end
            end
            KIND_STOP:
            begin
                active_next  = 1'b0;
                grace_next   = 1'b0;
                pos_next     = '0;
                flush        = 1'b1;
                used_next    = '0;
                flipped_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (use1)
        begin
            used_next    = t1.used;
            flipped_next = t1.flipped;
        end
        else if (use0)
        begin
            used_next    = t0.used;
            flipped_next = t0.flipped;
        end

        dir_next = dir_reg ^ (dir_enable & ((use0 & t0.flip) ^ (use1 & t1.flip)));

        q_ctrl.push    = fire & push;
        q_ctrl.entry   = '{flip_dir:     item.flip_dir,
                           with_step:    item.with_step,
                           repeat_count: item.repeat_count,
                           period_ticks: item.period_ticks};
        q_ctrl.pop_cnt = fire ? (2'(use0 & t0.pop) + 2'(use1 & t1.pop)) : 2'd0;
        q_ctrl.flush   = fire & flush;

        result.step_level = active_next & cur_pulse_next & (pos_next < pulse_width);
        result.dir_level  = dir_next;
        result.running    = active_next;
        result.accepted   = accepted;
        result.period_end = period_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cur_top_reg   <= CUR_TOP_RST;
            cur_pulse_reg <= 1'b0;
            stg_top_reg   <= '0;
            stg_pulse_reg <= 1'b0;
            grace_reg     <= 1'b0;
            active_reg    <= 1'b0;
            dir_reg       <= 1'b0;
            used_reg      <= '0;
            flipped_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            cur_top_reg   <= cur_top_next;
            cur_pulse_reg <= cur_pulse_next;
            stg_top_reg   <= stg_top_next;
            stg_pulse_reg <= stg_pulse_next;
            grace_reg     <= grace_next;
            active_reg    <= active_next;
            dir_reg       <= dir_next;
            used_reg      <= used_next;
            flipped_reg   <= flipped_next;
        end
    end

endmodule
